/* rtl/assert_macros.svh */
// Assertion helpers included by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");

// Checked outside reset only.
`define ASSERT_RUN(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`endif

/* rtl/ptpsms_pkg.sv */
// ----------------------------------------------------------------------------
// PTP source statistics package
// Sizes, the search word carried along the cell chain and the control states.
// ----------------------------------------------------------------------------
package ptpsms_pkg;

  localparam int NumSources = 16;
  localparam int TimeW      = 48;
  localparam int NumTypes   = 16;
  localparam int TypeW      = 4;
  localparam int SlotW      = (NumSources > 1) ? $clog2(NumSources) : 1;
  localparam int OutSlotW   = 4;
  localparam int CountW     = 32;
  localparam int SeqW       = 16;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [TypeW-1:0]  msg_type;
    logic [7:0]        domain;
    logic [63:0]       clock;
    logic [15:0]       port;
    logic [SeqW-1:0]   seq;
    logic [TimeW-1:0]  ts;
    logic [SlotW-1:0]  slot;
    logic              new_src;
    logic              anomaly;
    logic [CountW-1:0] type_count;
    logic [CountW-1:0] anom_total;
  } token_t;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StHold
  } state_e;

endpackage

/* rtl/ptp_source_message_statistics_core.sv */
// ----------------------------------------------------------------------------
// PTP source message statistics
// Counts parsed PTP headers per source, per message type and per anomaly.
// ----------------------------------------------------------------------------
// One word is handled at a time. An accepted word enters a chain of
// NumSources cells, one per source entry, and moves one cell per cycle; the
// cell holding its source, or the first free one, updates its counters. The
// result is held in hold_q and then loaded into the output register, after which
// the next word can be accepted; a new word is not taken while one is still in
// the chain. The next word is taken as soon as the result is in the output
// register, even before it has been read; a result only waits when the previous
// one is still unread in the output register.
module ptp_source_message_statistics_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  msg_type_i,
  input  logic [7:0]  domain_i,
  input  logic [63:0] clock_identity_i,
  input  logic [15:0] port_number_i,
  input  logic [15:0] sequence_id_i,
  input  logic [47:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  source_slot_o,
  output logic        new_source_o,
  output logic        table_full_o,
  output logic        seq_anomaly_o,
  output logic [31:0] type_count_o,
  output logic [31:0] anomaly_total_o,
  output logic [31:0] valid_total_o
);

  `include "assert_macros.svh"

  ptpsms_pkg::state_e          state_q, state_d;
  ptpsms_pkg::token_t          head_tok;
  ptpsms_pkg::token_t          chain [ptpsms_pkg::NumSources];
  ptpsms_pkg::token_t          tail_tok;
  ptpsms_pkg::token_t          hold_q;
  logic [31:0]                 total_q;
  logic                        out_valid_q;
  logic                        accept, out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    head_tok          = '0;
    head_tok.valid    = accept;
    head_tok.msg_type = msg_type_i;
    head_tok.domain   = domain_i;
    head_tok.clock    = clock_identity_i;
    head_tok.port     = port_number_i;
    head_tok.seq      = sequence_id_i;
    head_tok.ts       = ptpsms_pkg::TimeW'(timestamp_i);
  end

  for (genvar i = 0; i < ptpsms_pkg::NumSources; i++) begin : g_cell
    ptpsms_pkg::token_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = head_tok;
    end else begin : g_link
      assign cell_in = chain[i-1];
    end
    ptpsms_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .slot_i (ptpsms_pkg::SlotW'(i)),
      .tok_i  (cell_in),
      .tok_o  (chain[i])
    );
  end

  assign tail_tok = chain[ptpsms_pkg::NumSources-1];

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      ptpsms_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ptpsms_pkg::StSearch;
      end
      ptpsms_pkg::StSearch: begin
        if (tail_tok.valid) state_d = ptpsms_pkg::StHold;
      end
      ptpsms_pkg::StHold: begin
        if (out_free) state_d = ptpsms_pkg::StIdle;
      end
      default: state_d = ptpsms_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptpsms_pkg::StIdle;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) total_q <= total_q + 32'd1;
      if (state_q == ptpsms_pkg::StHold && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ptpsms_pkg::StSearch && tail_tok.valid) begin
      hold_q <= tail_tok;
    end
    if (state_q == ptpsms_pkg::StHold && out_free) begin
      // A word that no cell claimed found the table full and is dropped.
      source_slot_o   <= hold_q.hit ? ptpsms_pkg::OutSlotW'(hold_q.slot) : '0;
      new_source_o    <= hold_q.hit && hold_q.new_src;
      table_full_o    <= !hold_q.hit;
      seq_anomaly_o   <= hold_q.hit && hold_q.anomaly;
      type_count_o    <= hold_q.hit ? hold_q.type_count : '0;
      anomaly_total_o <= hold_q.hit ? hold_q.anom_total : '0;
      valid_total_o   <= total_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_tail_only_in_search,
    tail_tok.valid |-> state_q == ptpsms_pkg::StSearch)
  `ASSERT_RUN(a_accept_starts_search, accept |=> state_q == ptpsms_pkg::StSearch)
  `ASSERT_RUN(a_hold_loads_output,
    (state_q == ptpsms_pkg::StHold && out_free) |=> out_valid_o)

endmodule

/* rtl/ptpsms_cell.sv */
// ----------------------------------------------------------------------------
// PTP source statistics cell
// Holds one source entry; claims a passing word that matches it, or takes the
// word as a new source when the entry is still free.
// ----------------------------------------------------------------------------
module ptpsms_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ptpsms_pkg::SlotW-1:0] slot_i,
  input  ptpsms_pkg::token_t         tok_i,
  output ptpsms_pkg::token_t         tok_o
);

  logic                             used_q;
  logic [7:0]                       domain_q;
  logic [63:0]                      clock_q;
  logic [15:0]                      port_q;
  logic [ptpsms_pkg::TimeW-1:0]     first_q;
  logic [ptpsms_pkg::TimeW-1:0]     last_q;
  logic [ptpsms_pkg::CountW-1:0]    cnt_q  [ptpsms_pkg::NumTypes];
  logic [ptpsms_pkg::SeqW-1:0]      seq_q  [ptpsms_pkg::NumTypes];
  logic [ptpsms_pkg::NumTypes-1:0]  seqv_q, seqv_d;
  logic [ptpsms_pkg::CountW-1:0]    anom_q;
  ptpsms_pkg::token_t               tok_q, tok_d;

  logic                             hit_here, alloc_here, take;
  logic [ptpsms_pkg::CountW-1:0]    cnt_cur, anom_cur;
  logic                             anomaly;

  assign hit_here   = tok_i.valid && !tok_i.hit && used_q && domain_q == tok_i.domain &&
                      clock_q == tok_i.clock && port_q == tok_i.port;
  assign alloc_here = tok_i.valid && !tok_i.hit && !used_q;
  assign take       = hit_here || alloc_here;

  always_comb begin
    cnt_cur  = alloc_here ? '0 : cnt_q[tok_i.msg_type];
    anom_cur = alloc_here ? '0 : anom_q;
    // A new entry has no previous id of any type.
    anomaly  = !alloc_here && seqv_q[tok_i.msg_type] &&
               (tok_i.seq != seq_q[tok_i.msg_type] + ptpsms_pkg::SeqW'(1));
    seqv_d = alloc_here ? '0 : seqv_q;
    seqv_d[tok_i.msg_type] = 1'b1;
    tok_d = tok_i;
    if (take) begin
      tok_d.hit        = 1'b1;
      tok_d.slot       = slot_i;
      tok_d.new_src    = alloc_here;
      tok_d.anomaly    = anomaly;
      tok_d.type_count = cnt_cur + ptpsms_pkg::CountW'(1);
      tok_d.anom_total = anom_cur + ptpsms_pkg::CountW'(anomaly);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      used_q <= 1'b0;
      seqv_q <= '0;
    end else begin
      tok_q <= tok_d;
      if (alloc_here) begin
        used_q <= 1'b1;
      end
      if (take) begin
        seqv_q <= seqv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_here) begin
      domain_q <= tok_i.domain;
      clock_q  <= tok_i.clock;
      port_q   <= tok_i.port;
      first_q  <= tok_i.ts;
    end
    if (take) begin
      last_q <= tok_i.ts;
      for (int t = 0; t < ptpsms_pkg::NumTypes; t++) begin
        if (t == int'(tok_i.msg_type)) begin
          cnt_q[t] <= tok_d.type_count;
        end else if (alloc_here) begin
          cnt_q[t] <= '0;
        end
      end
      seq_q[tok_i.msg_type] <= tok_i.seq;
      anom_q                <= tok_d.anom_total;
    end
  end

  assign tok_o = tok_q;

endmodule

/* tb/ptp_source_message_statistics_core_tb.sv */
// ----------------------------------------------------------------------------
// PTP source message statistics testbench
// Drives parsed PTP headers into the core, predicts every result word from a
// behavioural copy of the source table and compares the two field by field.
// ----------------------------------------------------------------------------
module ptp_source_message_statistics_core_tb;

  typedef struct packed {
    logic [3:0]  msg_type;
    logic [7:0]  domain;
    logic [63:0] clock;
    logic [15:0] port;
    logic [15:0] seq;
    logic [47:0] ts;
  } hdr_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        new_src;
    logic        full;
    logic        anomaly;
    logic [31:0] type_count;
    logic [31:0] anom_total;
    logic [31:0] total;
  } stat_t;

  // Directed row: a header plus an optional typed-in result.
  typedef struct packed {
    hdr_t  hdr;
    logic  has_fixed;
    stat_t fixed;
  } row_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, out_ready_i;
  logic        in_ready_o, out_valid_o;
  logic [3:0]  msg_type_i;
  logic [7:0]  domain_i;
  logic [63:0] clock_identity_i;
  logic [15:0] port_number_i, sequence_id_i;
  logic [47:0] timestamp_i;
  logic [3:0]  source_slot_o;
  logic        new_source_o, table_full_o, seq_anomaly_o;
  logic [31:0] type_count_o, anomaly_total_o, valid_total_o;

  ptp_source_message_statistics_core u_top (.*);

  // Predictor state.
  logic [31:0] seen_total;
  int          n_sources;
  logic [7:0]  src_domain [ptpsms_pkg::NumSources];
  logic [63:0] src_clock  [ptpsms_pkg::NumSources];
  logic [15:0] src_port   [ptpsms_pkg::NumSources];
  logic [31:0] per_type   [ptpsms_pkg::NumSources][ptpsms_pkg::NumTypes];
  logic [15:0] prev_seq   [ptpsms_pkg::NumSources][ptpsms_pkg::NumTypes];
  logic        prev_ok    [ptpsms_pkg::NumSources][ptpsms_pkg::NumTypes];
  logic [31:0] anom_count [ptpsms_pkg::NumSources];

  stat_t  pending_stats[$];
  int     errors = 0;
  longint cycles = 0;
  int     send_idle = 37, recv_idle = 66;
  hdr_t   known[$];

  function automatic stat_t count_header(hdr_t h);
    stat_t r;
    int    s;
    r = '0;
    seen_total = seen_total + 32'd1;
    r.total = seen_total;
    s = -1;
    for (int i = 0; i < n_sources; i++)
      if (s < 0 && src_domain[i] == h.domain && src_clock[i] == h.clock &&
          src_port[i] == h.port) s = i;
    if (s < 0) begin
      if (n_sources >= ptpsms_pkg::NumSources) begin
        r.full = 1'b1;
        return r;
      end
      s = n_sources;
      n_sources++;
      src_domain[s] = h.domain;
      src_clock[s]  = h.clock;
      src_port[s]   = h.port;
      anom_count[s] = '0;
      for (int t = 0; t < ptpsms_pkg::NumTypes; t++) begin
        per_type[s][t] = '0;
        prev_ok[s][t]  = 1'b0;
      end
      r.new_src = 1'b1;
    end
    per_type[s][h.msg_type] = per_type[s][h.msg_type] + 32'd1;
    if (prev_ok[s][h.msg_type] && h.seq != prev_seq[s][h.msg_type] + 16'd1) begin
      anom_count[s] = anom_count[s] + 32'd1;
      r.anomaly = 1'b1;
    end
    prev_seq[s][h.msg_type] = h.seq;
    prev_ok[s][h.msg_type]  = 1'b1;
    r.slot       = s[3:0];
    r.type_count = per_type[s][h.msg_type];
    r.anom_total = anom_count[s];
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, checks each accepted word against the oldest one.
  always @(posedge clk_i) begin
    stat_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_stats.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = pending_stats[0];
          pending_stats.delete(0);
          if (source_slot_o !== e.slot) begin
            $error("source_slot exp %0d got %0d", e.slot, source_slot_o); errors++;
          end
          if (new_source_o !== e.new_src) begin
            $error("new_source exp %0d got %0d", e.new_src, new_source_o); errors++;
          end
          if (table_full_o !== e.full) begin
            $error("table_full exp %0d got %0d", e.full, table_full_o); errors++;
          end
          if (seq_anomaly_o !== e.anomaly) begin
            $error("seq_anomaly exp %0d got %0d", e.anomaly, seq_anomaly_o); errors++;
          end
          if (type_count_o !== e.type_count) begin
            $error("type_count exp %0d got %0d", e.type_count, type_count_o); errors++;
          end
          if (anomaly_total_o !== e.anom_total) begin
            $error("anomaly_total exp %0d got %0d", e.anom_total, anomaly_total_o);
            errors++;
          end
          if (valid_total_o !== e.total) begin
            $error("valid_total exp %0d got %0d", e.total, valid_total_o); errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Called at a rising edge; returns at the edge that accepts the word, with
  // valid still high so that a following word can go out back to back.
  task automatic send_header(hdr_t h, logic has_fixed, stat_t fixed);
    stat_t p;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    msg_type_i       <= h.msg_type;
    domain_i         <= h.domain;
    clock_identity_i <= h.clock;
    port_number_i    <= h.port;
    sequence_id_i    <= h.seq;
    timestamp_i      <= h.ts;
    do @(posedge clk_i); while (!in_ready_o);
    p = count_header(h);
    if (has_fixed && p !== fixed) begin
      $error("predictor disagrees with table row: exp %h got %h", fixed, p);
      errors++;
    end
    pending_stats = {pending_stats, p};
  endtask

  function automatic hdr_t random_header(bit fresh);
    hdr_t         h;
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    h = bits[$bits(hdr_t)-1:0];
    if (!fresh && known.size() > 0) begin
      hdr_t k;
      k = known[$urandom_range(known.size() - 1)];
      h.domain = k.domain; h.clock = k.clock; h.port = k.port;
      // Mostly in-order sequence ids for this type.
      if ($urandom_range(3) != 0 && n_sources > 0)
        for (int i = 0; i < n_sources; i++)
          if (src_domain[i] == h.domain && src_clock[i] == h.clock &&
              src_port[i] == h.port && prev_ok[i][h.msg_type])
            h.seq = prev_seq[i][h.msg_type] + 16'd1;
    end else if (known.size() < ptpsms_pkg::NumSources + 3) known = {known, h};
    return h;
  endfunction

  row_t rows[$];

  initial begin
    hdr_t  h;
    row_t  r;
    stat_t s;
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b0;
    msg_type_i = '0; domain_i = '0; clock_identity_i = '0; port_number_i = '0;
    sequence_id_i = '0; timestamp_i = '0;
    seen_total = '0; n_sources = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: zero key, all-ones key, wrap of sequence id, anomaly.
    h = '0;
    s = '0; s.new_src = 1'b1; s.type_count = 32'd1; s.total = 32'd1;
    r = '{h, 1'b1, s}; rows = {rows, r};
    h.seq = 16'd5;
    s = '0; s.anomaly = 1'b1; s.type_count = 32'd2; s.anom_total = 32'd1;
    s.total = 32'd2;
    r = '{h, 1'b1, s}; rows = {rows, r};
    h = '1; h.seq = 16'hFFFF;
    s = '0; s.slot = 4'd1; s.new_src = 1'b1; s.type_count = 32'd1; s.total = 32'd3;
    r = '{h, 1'b1, s}; rows = {rows, r};
    h.seq = 16'h0000; h.ts = '0;
    s = '0; s.slot = 4'd1; s.type_count = 32'd2; s.total = 32'd4;
    r = '{h, 1'b1, s}; rows = {rows, r};
    for (int t = 0; t < ptpsms_pkg::NumTypes; t++) begin
      h = '0; h.msg_type = t[3:0]; h.seq = 16'd100; h.clock = 64'hA5;
      r = '{h, 1'b0, '0}; rows = {rows, r};
    end
    // Fill the table, then one more unknown source must be dropped.
    for (int i = 0; i < ptpsms_pkg::NumSources - 3; i++) begin
      h = '0; h.port = 16'd1 + i[15:0];
      r = '{h, 1'b0, '0}; rows = {rows, r};
    end
    h = '0; h.port = 16'd100;
    s = '0; s.full = 1'b1; s.total = 32'd34;
    r = '{h, 1'b1, s}; rows = {rows, r};
    foreach (rows[i]) begin
      known = {known, rows[i].hdr};
      send_header(rows[i].hdr, rows[i].has_fixed, rows[i].fixed);
    end
    in_valid_i <= 1'b0;

    // Pause until drained, then random traffic in three idling phases.
    wait (pending_stats.size() == 0);
    @(posedge clk_i);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 37 : (ph == 1) ? 66 : 0;
      recv_idle = (ph == 0) ? 66 : (ph == 1) ? 37 : 0;
      for (int i = 0; i < 260; i++) begin
        h = random_header($urandom_range(15) == 0);
        send_header(h, 1'b0, '0);
      end
    end
    // Unknown sources against the full table.
    for (int i = 0; i < ptpsms_pkg::NumSources + 2; i++) begin
      h = random_header(1'b1);
      send_header(h, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_stats.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/ptpsms_pkg.sv
rtl/ptpsms_cell.sv
rtl/ptp_source_message_statistics_core.sv
tb/ptp_source_message_statistics_core_tb.sv
